FILE: rtl/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPLY(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

FILE: rtl/stlk_pkg.sv
`default_nettype none

package stlk_pkg;

	localparam int TABLE_DEPTH = 4096;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = ADDR_W + 1;

	localparam int ROW_W   = 12;
	localparam int PROT_W  = 8;
	localparam int NEUT_W  = 8;
	localparam int MASS_W  = 9;
	localparam int EXC_W   = 20;
	localparam int RCNT_W  = 13;
	localparam int START_W = 12;
	localparam int CFG_W   = 13;

	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 24;

	localparam logic [0:0] OPC_LOAD   = 1'b0;
	localparam logic [0:0] OPC_LOOKUP = 1'b1;

	localparam logic [0:0] REG_ROW_COUNT = 1'b0;
	localparam logic [0:0] REG_START_ROW = 1'b1;

	typedef struct packed {
		logic [MASS_W-1:0]       mass;
		logic [PROT_W-1:0]       prot;
		logic signed [EXC_W-1:0] excess;
	} row_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_MID,
		ST_EV_FIRST,
		ST_BS_TEST,
		ST_BS_EV,
		ST_RD_LO,
		ST_EV_LO,
		ST_RD_HI,
		ST_EV_HI,
		ST_WALK_RD,
		ST_WALK_EV,
		ST_HIT,
		ST_MISS
	} step_t;

	typedef enum logic [2:0] {
		ADR_NONE,
		ADR_MID,
		ADR_MP,
		ADR_LO,
		ADR_HI
	} addr_sel_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_ACCEPT,
		OP_BOUNDS,
		OP_LATCH_MP,
		OP_NARROW,
		OP_MID_LO,
		OP_MID_HI,
		OP_WALK,
		OP_EMIT_HIT,
		OP_EMIT_MISS
	} dp_op_t;

	typedef enum logic [2:0] {
		C_NEVER,
		C_START,
		C_N_ZERO,
		C_MASS_EQ,
		C_SPAN_NARROW,
		C_WALK_MISS,
		C_PROT_EQ,
		C_OUT_BUSY
	} cond_t;

	typedef struct packed {
		addr_sel_t addr_sel;
		dp_op_t    op;
		cond_t     cond_a;
		step_t     tgt_a;
		cond_t     cond_b;
		step_t     tgt_b;
		step_t     next;
	} ctl_t;

	typedef struct packed {
		logic start;
		logic n_zero;
		logic mass_eq;
		logic span_narrow;
		logic walk_miss;
		logic prot_eq;
		logic out_busy;
	} flags_t;

	// microprogram: one control word per step
	function automatic ctl_t ucode(input step_t s);
		ctl_t w;
		w = '{ADR_NONE, OP_NOP, C_NEVER, ST_IDLE, C_NEVER, ST_IDLE, ST_IDLE};
		unique case (s)
			ST_IDLE: begin
				w.op = OP_ACCEPT; w.cond_a = C_START; w.tgt_a = ST_RD_MID;
				w.next = ST_IDLE;
			end
			ST_RD_MID: begin
				w.addr_sel = ADR_MID; w.cond_a = C_N_ZERO; w.tgt_a = ST_MISS;
				w.next = ST_EV_FIRST;
			end
			ST_EV_FIRST: begin
				w.op = OP_BOUNDS; w.cond_a = C_MASS_EQ; w.tgt_a = ST_WALK_EV;
				w.next = ST_BS_TEST;
			end
			ST_BS_TEST: begin
				w.addr_sel = ADR_MP; w.op = OP_LATCH_MP;
				w.cond_a = C_SPAN_NARROW; w.tgt_a = ST_RD_LO;
				w.next = ST_BS_EV;
			end
			ST_BS_EV: begin
				w.op = OP_NARROW; w.next = ST_BS_TEST;
			end
			ST_RD_LO: begin
				w.addr_sel = ADR_LO; w.next = ST_EV_LO;
			end
			ST_EV_LO: begin
				w.op = OP_MID_LO; w.cond_a = C_MASS_EQ; w.tgt_a = ST_WALK_EV;
				w.next = ST_RD_HI;
			end
			ST_RD_HI: begin
				w.addr_sel = ADR_HI; w.op = OP_MID_HI; w.next = ST_EV_HI;
			end
			ST_EV_HI: begin
				w.cond_a = C_MASS_EQ; w.tgt_a = ST_WALK_EV; w.next = ST_MISS;
			end
			ST_WALK_RD: begin
				w.addr_sel = ADR_MID; w.next = ST_WALK_EV;
			end
			ST_WALK_EV: begin
				w.op = OP_WALK;
				w.cond_a = C_WALK_MISS; w.tgt_a = ST_MISS;
				w.cond_b = C_PROT_EQ; w.tgt_b = ST_HIT;
				w.next = ST_WALK_RD;
			end
			ST_HIT: begin
				w.op = OP_EMIT_HIT; w.cond_a = C_OUT_BUSY; w.tgt_a = ST_HIT;
				w.next = ST_IDLE;
			end
			ST_MISS: begin
				w.op = OP_EMIT_MISS; w.cond_a = C_OUT_BUSY; w.tgt_a = ST_MISS;
				w.next = ST_IDLE;
			end
			default: begin
				w.next = ST_IDLE;
			end
		endcase
		return w;
	endfunction

	function automatic logic cond_hit(input cond_t c, input flags_t f);
		logic r;
		unique case (c)
			C_NEVER:       r = 1'b0;
			C_START:       r = f.start;
			C_N_ZERO:      r = f.n_zero;
			C_MASS_EQ:     r = f.mass_eq;
			C_SPAN_NARROW: r = f.span_narrow;
			C_WALK_MISS:   r = f.walk_miss;
			C_PROT_EQ:     r = f.prot_eq;
			C_OUT_BUSY:    r = f.out_busy;
			default:       r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/sorted_table_two_key_lookup_unit.sv
`default_nettype none
// Lookup in a table sorted by mass number, then by proton count. A load transaction
// (tuser = 0) writes one row. A lookup transaction (tuser = 1) runs a short
// microprogram over the row memory, which has a single read port: each memory probe
// puts out an address, then compares against the registered read data. A lookup
// probes the start row first and walks on proton count when that row holds the
// mass number; else it bounds the search on one side of the start row, narrows it
// by binary search, probes the lower then the upper bound row and walks from the
// first that matches, or reports a miss. No new transaction is taken until a
// lookup is done. The result (found on tuser, mass excess on tdata, zero when not
// found) sits in an output register; the next transaction is taken while it waits,
// and a finished lookup holds while that register is full and not being taken. A
// proton walk that would turn back, or that runs off either end of the table,
// reports not found. Configuration must be written by the user only while no
// lookup is in flight; the block itself does not enforce it.

`include "assert_macros.svh"

module sorted_table_two_key_lookup_unit (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_axis_tvalid,
	output logic                                      s_axis_tready,
	// row[11:0], protons[19:12], neutrons[27:20], excess_in[47:28]
	input  wire logic [stlk_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// opcode[0]
	input  wire logic [0:0]                           s_axis_tuser,
	output logic                                      m_axis_tvalid,
	input  wire logic                                 m_axis_tready,
	// excess_out[19:0], zeros[23:20]
	output logic [stlk_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
	// found[0]
	output logic [0:0]                                m_axis_tuser,
	input  wire logic                                 cfg_we,
	input  wire logic [0:0]                           cfg_index,
	input  wire logic [stlk_pkg::CFG_W-1:0]           cfg_data
);

	localparam int ADDR_W = stlk_pkg::ADDR_W;
	localparam int CNT_W  = stlk_pkg::CNT_W;

	// input fields
	logic [stlk_pkg::ROW_W-1:0]        in_row;
	logic [stlk_pkg::PROT_W-1:0]       in_prot;
	logic [stlk_pkg::NEUT_W-1:0]       in_neut;
	logic signed [stlk_pkg::EXC_W-1:0] in_exc;
	logic [stlk_pkg::MASS_W-1:0]       in_mass;

	assign in_row  = s_axis_tdata[11:0];
	assign in_prot = s_axis_tdata[19:12];
	assign in_neut = s_axis_tdata[27:20];
	assign in_exc  = s_axis_tdata[47:28];
	assign in_mass = stlk_pkg::MASS_W'(in_prot) + stlk_pkg::MASS_W'(in_neut);

	// configuration
	logic [stlk_pkg::RCNT_W-1:0]  row_count_q;
	logic [stlk_pkg::START_W-1:0] start_row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= '0;
			start_row_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				stlk_pkg::REG_ROW_COUNT: row_count_q <= cfg_data[stlk_pkg::RCNT_W-1:0];
				stlk_pkg::REG_START_ROW: start_row_q <= cfg_data[stlk_pkg::START_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	stlk_pkg::step_t  pc_q, pc_d;
	stlk_pkg::ctl_t   ctl;
	stlk_pkg::flags_t flags;

	// datapath registers
	logic [stlk_pkg::MASS_W-1:0] a_q;
	logic [stlk_pkg::PROT_W-1:0] z_q;
	logic [CNT_W-1:0]            n_q;
	logic [ADDR_W-1:0]           mid_q, lo_q, hi_q, mp_q;
	logic                        dir_up_q, dir_dn_q;
	stlk_pkg::row_t              rd_q;
	logic                        out_valid_q, found_q;
	logic signed [stlk_pkg::EXC_W-1:0] excess_q;

	logic [CNT_W-1:0]  n_eff;
	logic [ADDR_W-1:0] mid_init;
	logic [CNT_W-1:0]  span_sum;
	logic [ADDR_W-1:0] mp_c;
	logic              out_busy;
	logic              accept;
	logic              emit;
	logic              walk_stop;

	assign ctl = stlk_pkg::ucode(pc_q);

	assign s_axis_tready = (ctl.op == stlk_pkg::OP_ACCEPT);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_busy      = out_valid_q && !m_axis_tready;
	assign emit          = ((ctl.op == stlk_pkg::OP_EMIT_HIT) ||
	                        (ctl.op == stlk_pkg::OP_EMIT_MISS)) && !out_busy;

	assign n_eff = (32'(row_count_q) > 32'(stlk_pkg::TABLE_DEPTH)) ?
	               CNT_W'(stlk_pkg::TABLE_DEPTH) : CNT_W'(row_count_q);
	assign mid_init = (CNT_W'(start_row_q) >= n_eff) ?
	                  ADDR_W'(n_eff - CNT_W'(1)) : ADDR_W'(start_row_q);

	assign span_sum = CNT_W'(lo_q) + CNT_W'(hi_q);
	assign mp_c     = ADDR_W'(span_sum >> 1);

	assign walk_stop = ((rd_q.prot > z_q) && (dir_up_q || (mid_q == '0))) ||
	                   ((rd_q.prot < z_q) &&
	                    (dir_dn_q || (CNT_W'(mid_q) >= n_q - CNT_W'(1))));

	always_comb begin
		flags.start       = accept && (s_axis_tuser == stlk_pkg::OPC_LOOKUP);
		flags.n_zero      = (n_q == '0);
		flags.mass_eq     = (rd_q.mass == a_q);
		flags.span_narrow = !(CNT_W'(hi_q) > CNT_W'(lo_q) + CNT_W'(1));
		flags.walk_miss   = (rd_q.mass != a_q) || walk_stop;
		flags.prot_eq     = (rd_q.prot == z_q);
		flags.out_busy    = out_busy;
	end

	always_comb begin
		priority if (stlk_pkg::cond_hit(ctl.cond_a, flags)) begin
			pc_d = ctl.tgt_a;
		end else if (stlk_pkg::cond_hit(ctl.cond_b, flags)) begin
			pc_d = ctl.tgt_b;
		end else begin
			pc_d = ctl.next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= stlk_pkg::ST_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

	// row memory: one write and one registered read per cycle
	stlk_pkg::row_t mem [stlk_pkg::TABLE_DEPTH];
	logic              mem_we;
	logic              mem_re;
	logic [ADDR_W-1:0] rd_addr;
	stlk_pkg::row_t    wr_row;

	assign mem_we = accept && (s_axis_tuser == stlk_pkg::OPC_LOAD) &&
	                (32'(in_row) < 32'(stlk_pkg::TABLE_DEPTH));
	assign mem_re = (ctl.addr_sel != stlk_pkg::ADR_NONE);
	assign wr_row = '{mass: in_mass, prot: in_prot, excess: in_exc};

	always_comb begin
		unique case (ctl.addr_sel)
			stlk_pkg::ADR_MID: rd_addr = mid_q;
			stlk_pkg::ADR_MP:  rd_addr = mp_c;
			stlk_pkg::ADR_LO:  rd_addr = lo_q;
			stlk_pkg::ADR_HI:  rd_addr = hi_q;
			default:           rd_addr = mid_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[ADDR_W'(in_row)] <= wr_row;
		end
		if (mem_re) begin
			rd_q <= mem[rd_addr];
		end
	end

	// search registers
	always_ff @(posedge clk) begin
		unique case (ctl.op)
			stlk_pkg::OP_ACCEPT: begin
				if (flags.start) begin
					a_q      <= in_mass;
					z_q      <= in_prot;
					n_q      <= n_eff;
					mid_q    <= mid_init;
					dir_up_q <= 1'b0;
					dir_dn_q <= 1'b0;
				end
			end
			stlk_pkg::OP_BOUNDS: begin
				if (rd_q.mass > a_q) begin
					lo_q <= '0;
					hi_q <= mid_q;
				end else begin
					lo_q <= mid_q;
					hi_q <= ADDR_W'(n_q - CNT_W'(1));
				end
			end
			stlk_pkg::OP_LATCH_MP: mp_q <= mp_c;
			stlk_pkg::OP_NARROW: begin
				if (rd_q.mass < a_q) begin
					lo_q <= mp_q;
				end else begin
					hi_q <= mp_q;
				end
			end
			stlk_pkg::OP_MID_LO: mid_q <= lo_q;
			stlk_pkg::OP_MID_HI: mid_q <= hi_q;
			stlk_pkg::OP_WALK: begin
				if (rd_q.prot > z_q) begin
					dir_dn_q <= 1'b1;
					mid_q    <= mid_q - ADDR_W'(1);
				end else begin
					dir_up_q <= 1'b1;
					mid_q    <= mid_q + ADDR_W'(1);
				end
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			found_q  <= (ctl.op == stlk_pkg::OP_EMIT_HIT);
			excess_q <= (ctl.op == stlk_pkg::OP_EMIT_HIT) ? rd_q.excess : '0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = found_q;
	assign m_axis_tdata  = {{(stlk_pkg::OUT_TDATA_W - stlk_pkg::EXC_W){1'b0}}, excess_q};

	`ASSERT_IMPLY(a_miss_is_zero, clk, arst_n, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == '0)
	`ASSERT_IMPLY(a_walk_in_range, clk, arst_n, pc_q == stlk_pkg::ST_WALK_RD, CNT_W'(mid_q) < n_q)
	`ASSERT_IMPLY(a_bounds_order, clk, arst_n, pc_q == stlk_pkg::ST_BS_TEST, lo_q <= hi_q)
	`ASSERT_NEXT(a_lookup_starts, clk, arst_n, flags.start, pc_q == stlk_pkg::ST_RD_MID)

endmodule

`default_nettype wire

FILE: sim/sorted_table_two_key_lookup_unit_test.sv
`default_nettype none

typedef struct packed {
	bit        found;
	bit [19:0] excess;
} answer_t;

class excess_scoreboard;
	bit [8:0]  mass_tab [stlk_pkg::TABLE_DEPTH];
	bit [7:0]  prot_tab [stlk_pkg::TABLE_DEPTH];
	bit [19:0] exc_tab [stlk_pkg::TABLE_DEPTH];
	int unsigned row_count;
	int unsigned start_row;
	answer_t answer_q [$];
	int mismatches;
	int results;
	int found_count;
	int loads;
	int lookups;

	function void write_reg(bit [0:0] idx, bit [12:0] value);
		if (idx == stlk_pkg::REG_ROW_COUNT) begin
			row_count = 32'(value);
		end else begin
			start_row = 32'(value[11:0]);
		end
	endfunction

	function int eff_rows();
		return (row_count > stlk_pkg::TABLE_DEPTH) ? stlk_pkg::TABLE_DEPTH : row_count;
	endfunction

	// probe start row, binary search on mass number, then walk over proton count
	function bit locate_entry(bit [8:0] a, bit [7:0] z, output int hit);
		int n;
		int mid;
		int lo;
		int hi;
		int mp;
		int dir;
		hit = 0;
		dir = 0;
		n = eff_rows();
		if (n == 0) return 1'b0;
		mid = (start_row >= n) ? n - 1 : start_row;
		if (mass_tab[mid] != a) begin
			if (mass_tab[mid] > a) begin
				lo = 0;
				hi = mid;
			end else begin
				lo = mid;
				hi = n - 1;
			end
			while (hi > lo + 1) begin
				mp = (lo + hi) / 2;
				if (mass_tab[mp] < a) lo = mp;
				else hi = mp;
			end
			mid = lo;
			if (mass_tab[mid] != a) mid = hi;
			if (mass_tab[mid] != a) return 1'b0;
		end
		while (mass_tab[mid] == a) begin
			if (prot_tab[mid] == z) begin
				hit = mid;
				return 1'b1;
			end
			if (prot_tab[mid] > z) begin
				if (dir > 0 || mid == 0) return 1'b0;
				dir = -1;
				mid--;
			end else begin
				if (dir < 0 || mid >= n - 1) return 1'b0;
				dir = 1;
				mid++;
			end
		end
		return 1'b0;
	endfunction

	function void note_item(bit [0:0] op, bit [11:0] row, bit [7:0] z, bit [7:0] nn,
			bit [19:0] exc);
		bit [8:0] a;
		bit       ok;
		int       hit;
		answer_t  ans;
		a = {1'b0, z} + {1'b0, nn};
		if (op == stlk_pkg::OPC_LOAD) begin
			mass_tab[row] = a;
			prot_tab[row] = z;
			exc_tab[row] = exc;
			loads++;
		end else begin
			lookups++;
			ok = locate_entry(a, z, hit);
			ans.found = ok;
			ans.excess = ok ? exc_tab[hit] : 20'd0;
			answer_q.push_back(ans);
		end
	endfunction

	function void check_result(bit found, bit [19:0] exc);
		answer_t want;
		if (answer_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result: found %0d excess %0d", found, $signed(exc));
			return;
		end
		want = answer_q.pop_front();
		results++;
		if (want.found) found_count++;
		if (want.found != found) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result %0d: found expected %0d actual %0d", results, want.found,
					found);
		end
		if (want.excess != exc) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result %0d: excess expected %0d actual %0d", results,
					$signed(want.excess), $signed(exc));
		end
	endfunction
endclass

module sorted_table_two_key_lookup_unit_test;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	wire logic              s_axis_tready;
	// row[11:0], protons[19:12], neutrons[27:20], excess_in[47:28]
	logic [stlk_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
	// opcode[0]
	logic [0:0]             s_axis_tuser = '0;
	wire logic              m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// excess_out[19:0], zeros[23:20]
	wire logic [stlk_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	// found[0]
	wire logic [0:0]        m_axis_tuser;
	logic                   cfg_we = 1'b0;
	logic [0:0]             cfg_index = '0;
	logic [stlk_pkg::CFG_W-1:0] cfg_data = '0;

	excess_scoreboard sb = new;
	int burst_left = 0;
	int settings_used = 0;

	bit [7:0]  seed_prot [7] = '{8'd0, 8'd10, 8'd12, 8'd14, 8'd0, 8'd5, 8'd255};
	bit [7:0]  seed_neut [7] = '{8'd0, 8'd10, 8'd8, 8'd6, 8'd30, 8'd25, 8'd255};
	bit [19:0] seed_excess [7] = '{20'h00001, 20'h80000, 20'h7FFFF, 20'h0004D, 20'hFFFFF,
		20'h004D2, 20'h7FFFF};
	bit [7:0]  probe_prot [10] = '{8'd10, 8'd11, 8'd13, 8'd9, 8'd15, 8'd0, 8'd255, 8'd255,
		8'd6, 8'd0};
	bit [7:0]  probe_neut [10] = '{8'd10, 8'd9, 8'd7, 8'd11, 8'd5, 8'd0, 8'd255, 8'd254,
		8'd24, 8'd30};

	sorted_table_two_key_lookup_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial forever #5 clk = ~clk;

	initial begin
		#40000000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic bit [19:0] rand_excess();
		case ($urandom_range(0, 7))
			0: return 20'h80000;
			1: return 20'h7FFFF;
			default: return 20'($urandom_range(0, 20'hFFFFF));
		endcase
	endfunction

	task automatic push_item(bit [0:0] op, bit [11:0] row, bit [7:0] z, bit [7:0] nn,
			bit [19:0] exc);
		int gap;
		if (burst_left == 0) begin
			case ($urandom_range(0, 3))
				1: gap = $urandom_range(1, 3);
				2: gap = $urandom_range(4, 20);
				default: gap = 0;
			endcase
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {exc, nn, z, row};
		s_axis_tuser <= op;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_item(op, row, z, nn, exc);
		burst_left--;
	endtask

	task automatic issue_lookup(bit [7:0] z, bit [7:0] nn);
		push_item(stlk_pkg::OPC_LOOKUP, 12'($urandom_range(0, 4095)), z, nn, rand_excess());
	endtask

	task automatic set_config(int unsigned rc, int unsigned st);
		s_axis_tvalid <= 1'b0;
		while (sb.answer_q.size() != 0) @(posedge clk);
		repeat (64) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= stlk_pkg::REG_ROW_COUNT;
		cfg_data <= rc[stlk_pkg::CFG_W-1:0];
		@(posedge clk);
		sb.write_reg(stlk_pkg::REG_ROW_COUNT, rc[stlk_pkg::CFG_W-1:0]);
		cfg_index <= stlk_pkg::REG_START_ROW;
		cfg_data <= st[stlk_pkg::CFG_W-1:0];
		@(posedge clk);
		sb.write_reg(stlk_pkg::REG_START_ROW, st[stlk_pkg::CFG_W-1:0]);
		cfg_we <= 1'b0;
		burst_left = 0;
		settings_used++;
	endtask

	// sorted rows: mass number climbs from base over span, protons climb within a mass
	task automatic load_table(int n, int base, int span);
		int r;
		int a;
		int prev;
		int z;
		int zlo;
		int zhi;
		prev = -1;
		z = 0;
		for (r = 0; r < n; r++) begin
			a = base + (r * span) / n;
			if (a > 510) a = 510;
			zlo = (a > 255) ? a - 255 : 0;
			zhi = (a < 255) ? a : 255;
			if (a != prev) z = zlo + $urandom_range(0, 3);
			else z = z + $urandom_range(1, 3);
			if (z > zhi) z = zhi;
			prev = a;
			push_item(stlk_pkg::OPC_LOAD, r[11:0], z[7:0], 8'(a - z), rand_excess());
		end
	endtask

	task automatic run_phase(int count);
		int k;
		int r;
		int eff;
		int zi;
		int ni;
		repeat (count) begin
			eff = sb.eff_rows();
			r = $urandom_range(0, (eff > 0) ? eff - 1 : 0);
			zi = 32'(sb.prot_tab[r]);
			ni = 32'(sb.mass_tab[r]) - 32'(sb.prot_tab[r]);
			k = $urandom_range(0, 19);
			if (k < 16) begin
				case (k % 8)
					5, 6: begin
						if ($urandom_range(0, 1)) begin
							zi++;
							ni--;
						end else begin
							zi--;
							ni++;
						end
					end
					7: ni += $urandom_range(0, 1) ? 1 : -1;
					default: ;
				endcase
				if (k == 15 || zi < 0 || zi > 255 || ni < 0 || ni > 255) begin
					zi = $urandom_range(0, 255);
					ni = $urandom_range(0, 255);
				end
				issue_lookup(zi[7:0], ni[7:0]);
			end else if (k < 19) begin
				push_item(stlk_pkg::OPC_LOAD, r[11:0], zi[7:0], ni[7:0], rand_excess());
			end else begin
				push_item(stlk_pkg::OPC_LOAD, 12'($urandom_range(0, 4095)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), rand_excess());
			end
		end
	endtask

	// result side: check each transaction, stall on a mode that changes now and then
	initial begin
		int stall_left;
		int stall_mode;
		stall_left = 0;
		stall_mode = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready)
				sb.check_result(m_axis_tuser[0], m_axis_tdata[19:0]);
			if (stall_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_left = $urandom_range(1, 60);
			end
			stall_left--;
			case (stall_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= 1'($urandom_range(0, 1));
				2: m_axis_tready <= ($urandom_range(0, 7) == 0);
				default: m_axis_tready <= (stall_left > 30);
			endcase
		end
	end

	initial begin
		int i;
		int p;
		int n;
		int span;
		int base;
		int st;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		set_config(0, 0);
		for (i = 0; i < 7; i++)
			push_item(stlk_pkg::OPC_LOAD, i[11:0], seed_prot[i], seed_neut[i], seed_excess[i]);
		issue_lookup(probe_prot[0], probe_neut[0]);
		set_config(7, 2);
		for (i = 0; i < 10; i++)
			issue_lookup(probe_prot[i], probe_neut[i]);
		set_config(7, 4095);
		for (i = 0; i < 7; i++)
			issue_lookup(probe_prot[i], probe_neut[i]);

		load_table(200, 0, 511);
		set_config(200, 100);
		run_phase(60);
		set_config(200, 4095);
		run_phase(60);
		set_config(200, 0);
		run_phase(60);

		for (p = 0; p < 7; p++) begin
			n = (p == 0) ? 1 : (p == 1) ? 2 : $urandom_range(3, 48);
			span = $urandom_range(0, n);
			base = $urandom_range(0, 510 - span);
			load_table(n, base, span);
			st = $urandom_range(0, 1) ? n / 2 : $urandom_range(0, 4095);
			if (p == 0) st = 4095;
			set_config(n, st);
			run_phase(60);
		end

		s_axis_tvalid <= 1'b0;
		while (sb.answer_q.size() != 0) @(posedge clk);
		repeat (64) @(posedge clk);
		$display("covered %0d loads and %0d lookups (%0d found) over %0d table settings",
			sb.loads, sb.lookups, sb.found_count, settings_used);
		$display("mismatches: %0d", sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire

FILE: files.f
+incdir+rtl
rtl/stlk_pkg.sv
rtl/sorted_table_two_key_lookup_unit.sv
sim/sorted_table_two_key_lookup_unit_test.sv
